// ===== rtl/core/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// Shared constants and types for the polyphase rational resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

    // field widths fixed by the stream format
    localparam int REG_W       = 9;    // config register width
    localparam int IDX_W       = 15;   // coefficient index width
    localparam int COEF_W      = 18;   // Q1.17 coefficient
    localparam int PHASE_W     = 8;
    localparam int ROUND_SHIFT = 17;   // Q.17 product scaling
    localparam int DIV_W       = 17;   // phase*down fits 17 bits
    localparam int DIV_CNT_W   = 5;

    // APB
    localparam int PADDR_W = 4;
    localparam int APB_W   = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_UP   = 2'd0;
    localparam logic [1:0] REG_DOWN = 2'd1;
    localparam logic [1:0] REG_TAPS = 2'd2;

    localparam logic [REG_W-1:0] UP_RESET   = 9'd1;
    localparam logic [REG_W-1:0] DOWN_RESET = 9'd1;
    localparam logic [REG_W-1:0] TAPS_RESET = 9'd162;
    localparam logic [REG_W-1:0] RATIO_MAX  = 9'd256;

    // input item kind (tuser)
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic valid;   // operands valid this cycle
        logic round;   // round/saturate the accumulator into the result
    } mac_ctl_t;

endpackage

// ===== rtl/core/prr_div.sv =====
// ----------------------------------------------------------------------------
// prr_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prr_div
    import prr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [REG_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [REG_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [REG_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= REG_W'(trial - {1'b0, divisor});
                end
                else
                begin
                    rem_reg <= trial[REG_W-1:0];
                end
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/prr_mac.sv =====
// ----------------------------------------------------------------------------
// prr_mac
// Shared multiply-accumulate unit with round-half-up and saturation.
// ----------------------------------------------------------------------------
module prr_mac
    import prr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_W       = 52
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mac_ctl_t                      ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [COEF_W-1:0]      coef,
    output logic                          busy,
    output logic        [SAMPLE_BITS-1:0] result
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SAMPLE_BITS-1:0]   result_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W-1:0]  sat;

    always_comb
    begin
        rnd     = acc_reg + HALF;
        shifted = rnd >>> ROUND_SHIFT;
        if (shifted > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (shifted < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.valid & ~ctl.clear;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // product and result are payload
    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coef;
        if (ctl.round)
        begin
            result_reg <= sat[SAMPLE_BITS-1:0];
        end
    end

    assign busy   = prod_vld_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/polyphase_rational_resampler.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// A coefficient write, or a sample with no output due, is taken while idle and
// leaves the block idle. A sample that triggers outputs gives n outputs (n <= 2);
// further phase steps due on it are dropped, each still running the divider.
// The single MAC (one tap per cycle) and the divider set how long this takes.
// No new item is taken before the last is done. Reset clears history, phase and
// config; the coefficient table has no reset and must be loaded before use.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler
    import prr_pkg::*;
#(
    parameter int MAX_TAPS    = 256,
    parameter int COEF_DEPTH  = 32768,   // power of two
    parameter int SAMPLE_BITS = 24,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + IDX_W + COEF_W + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
)(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample_in, coef_index, coef_value
    input  logic                 s_tuser,   // kind
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // sample_out
    output logic                 m_tlast,   // last
    // APB config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]     pwdata,
    output logic [APB_W-1:0]     prdata,
    output logic                 pready
);

    localparam int HA_W   = $clog2(MAX_TAPS);        // history address
    localparam int TAP_W  = $clog2(MAX_TAPS + 1);    // tap count 1..MAX_TAPS
    localparam int HS_W   = TAP_W + 1;               // history start sum
    localparam int CA_W   = $clog2(COEF_DEPTH);      // coefficient address
    localparam int ROW_W  = PHASE_W + TAP_W;         // phase*taps
    localparam int TCMP_W = (TAP_W > REG_W) ? TAP_W : REG_W;
    localparam int CS_A   = (ROW_W > CA_W) ? ROW_W : CA_W;
    localparam int CSUM_W = ((CS_A > IDX_W) ? CS_A : IDX_W) + 1;
    localparam int ACC_W  = SAMPLE_BITS + COEF_W + TAP_W + 1;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV0  = 4'd1;   // start floor(phase*down/up)
    localparam logic [3:0] ST_DIV0W = 4'd2;
    localparam logic [3:0] ST_ROW   = 4'd3;   // set up one dot product
    localparam logic [3:0] ST_MAC   = 4'd4;   // one tap per cycle
    localparam logic [3:0] ST_DRAIN = 4'd5;
    localparam logic [3:0] ST_ROUND = 4'd6;
    localparam logic [3:0] ST_STEP  = 4'd7;   // start floor((phase+1)*down/up)
    localparam logic [3:0] ST_STEPW = 4'd8;
    localparam logic [3:0] ST_PUSH  = 4'd9;   // hand result to output register

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] up_reg;
    logic [REG_W-1:0] down_reg;
    logic [REG_W-1:0] taps_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= UP_RESET;
            down_reg <= DOWN_RESET;
            taps_reg <= TAPS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_UP:   up_reg   <= pwdata[REG_W-1:0];
                REG_DOWN: down_reg <= pwdata[REG_W-1:0];
                REG_TAPS: taps_reg <= pwdata[REG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_UP:   prdata = APB_W'(up_reg);
            REG_DOWN: prdata = APB_W'(down_reg);
            REG_TAPS: prdata = APB_W'(taps_reg);
            default:  prdata = '0;
        endcase
    end

    // Effective values: zero reads as one, large values clamp.
    logic [REG_W-1:0]  up_eff;
    logic [REG_W-1:0]  down_eff;
    logic [TCMP_W-1:0] taps_cmp;
    logic [TAP_W-1:0]  taps_eff;

    always_comb
    begin
        up_eff   = (up_reg == '0) ? REG_W'(1) :
                   ((up_reg > RATIO_MAX) ? RATIO_MAX : up_reg);
        down_eff = (down_reg == '0) ? REG_W'(1) :
                   ((down_reg > RATIO_MAX) ? RATIO_MAX : down_reg);
        taps_cmp = TCMP_W'(taps_reg);
        if (taps_reg == '0)
        begin
            taps_eff = TAP_W'(1);
        end
        else if (taps_cmp > TCMP_W'(MAX_TAPS))
        begin
            taps_eff = TAP_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TAP_W'(taps_cmp);
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and handshake
    // ------------------------------------------------------------------
    logic [3:0]                    state_reg;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic [IDX_W-1:0]              s_index;
    logic signed [COEF_W-1:0]      s_coef;
    logic                          in_xfer;
    logic                          smp_xfer;
    logic                          coef_xfer;

    assign s_sample  = s_tdata[SAMPLE_BITS-1:0];
    assign s_index   = s_tdata[SAMPLE_BITS +: IDX_W];
    assign s_coef    = s_tdata[SAMPLE_BITS+IDX_W +: COEF_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid & s_tready;
    assign smp_xfer  = in_xfer & (s_tuser == KIND_SAMPLE);
    assign coef_xfer = in_xfer & (s_tuser == KIND_COEF);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] phase_reg;
    logic [REG_W-1:0]   stno_reg;     // samples still to skip
    logic [REG_W-1:0]   qcur_reg;     // floor(phase*down/up)
    logic [REG_W-1:0]   delta_reg;
    logic [1:0]         n_reg;        // results delivered for this sample
    logic               made_reg;     // result waiting in the MAC
    logic [HA_W-1:0]    hist_wr_reg;
    logic [TAP_W-1:0]   fill_reg;     // samples in history, saturating
    logic [ROW_W-1:0]   base_reg;
    logic [TAP_W-1:0]   tap_cnt_reg;
    logic [HA_W-1:0]    hidx_reg;
    logic [TAP_W-1:0]   age_reg;
    logic               rd_vld_reg;
    logic               hv_reg;

    // output register
    logic                   out_vld_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   out_free;

    // ------------------------------------------------------------------
    // Address and phase arithmetic
    // ------------------------------------------------------------------
    logic [HA_W-1:0]   hist_wr_inc;
    logic [HA_W-1:0]   hidx_inc;
    logic [HS_W-1:0]   hs_sum;
    logic [HA_W-1:0]   hidx_start;
    logic [ROW_W-1:0]  row_base;
    logic [CSUM_W-1:0] csum;
    logic [CSUM_W-1:0] widx;
    logic [CA_W-1:0]   coef_raddr;
    logic [CA_W-1:0]   coef_waddr;
    logic              hv;
    logic              phase_ge;
    logic [REG_W-1:0]  phase_inc;
    logic              wrap;
    logic [REG_W-1:0]  div_num;
    logic [DIV_W-1:0]  dividend;
    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [REG_W-1:0]  delta;

    assign hist_wr_inc = (hist_wr_reg == HA_W'(MAX_TAPS - 1)) ? '0 : hist_wr_reg + 1'b1;
    assign hidx_inc    = (hidx_reg == HA_W'(MAX_TAPS - 1)) ? '0 : hidx_reg + 1'b1;

    // oldest sample of the window: hist_wr - taps, modulo MAX_TAPS
    assign hs_sum     = HS_W'(hist_wr_reg) + HS_W'(MAX_TAPS) - HS_W'(taps_eff);
    assign hidx_start = (hs_sum >= HS_W'(MAX_TAPS)) ? HA_W'(hs_sum - HS_W'(MAX_TAPS))
                                                    : HA_W'(hs_sum);

    assign row_base   = ROW_W'(phase_reg) * ROW_W'(taps_eff);
    assign csum       = CSUM_W'(base_reg) + CSUM_W'(tap_cnt_reg);
    assign coef_raddr = csum[CA_W-1:0];     // modulo table depth
    assign widx       = CSUM_W'(s_index);
    assign coef_waddr = widx[CA_W-1:0];

    // entries older than the fill count are the zero lead-in
    assign hv = (age_reg < fill_reg);

    assign phase_ge  = ({1'b0, phase_reg} >= up_eff);
    assign phase_inc = REG_W'(phase_reg) + 1'b1;
    assign wrap      = (phase_inc == up_eff);

    assign div_num   = (state_reg == ST_DIV0) ? REG_W'(phase_reg) : phase_inc;
    assign dividend  = DIV_W'(div_num) * DIV_W'(down_eff);
    assign div_start = (state_reg == ST_DIV0) | (state_reg == ST_STEP);
    assign delta     = div_quo[REG_W-1:0] - qcur_reg;

    prr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (up_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Memories: coefficient table and sample history
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0]      coef_mem [COEF_DEPTH];
    logic signed [COEF_W-1:0]      coef_q;
    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_q;

    always_ff @(posedge clk)
    begin
        if (coef_xfer)
        begin
            coef_mem[coef_waddr] <= s_coef;
        end
        coef_q <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (smp_xfer)
        begin
            hist_mem[hist_wr_reg] <= s_sample;
        end
        hist_q <= hist_mem[hidx_reg];
    end

    // ------------------------------------------------------------------
    // Shared MAC
    // ------------------------------------------------------------------
    mac_ctl_t                      mac_ctl;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic                          mac_busy;
    logic [SAMPLE_BITS-1:0]        mac_result;

    assign mac_ctl.clear = (state_reg == ST_ROW);
    assign mac_ctl.valid = rd_vld_reg;
    assign mac_ctl.round = (state_reg == ST_ROUND);
    assign mac_sample    = hv_reg ? hist_q : '0;

    prr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (mac_sample),
        .coef   (coef_q),
        .busy   (mac_busy),
        .result (mac_result)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = ~out_vld_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            stno_reg    <= '0;
            qcur_reg    <= '0;
            delta_reg   <= '0;
            n_reg       <= '0;
            made_reg    <= 1'b0;
            hist_wr_reg <= '0;
            fill_reg    <= '0;
            base_reg    <= '0;
            tap_cnt_reg <= '0;
            hidx_reg    <= '0;
            age_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            hv_reg      <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == ST_MAC);
            hv_reg     <= hv;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (smp_xfer)
                    begin
                        hist_wr_reg <= hist_wr_inc;
                        if (fill_reg != TAP_W'(MAX_TAPS))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        n_reg    <= '0;
                        made_reg <= 1'b0;
                        if (stno_reg != '0)
                        begin
                            stno_reg <= stno_reg - 1'b1;
                        end
                        else
                        begin
                            // phase restarts if up_factor shrank below it
                            if (phase_ge)
                            begin
                                phase_reg <= '0;
                            end
                            state_reg <= ST_DIV0;
                        end
                    end
                end
                ST_DIV0:
                begin
                    state_reg <= ST_DIV0W;
                end
                ST_DIV0W:
                begin
                    if (div_done)
                    begin
                        qcur_reg  <= div_quo[REG_W-1:0];
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW:
                begin
                    base_reg    <= row_base;
                    tap_cnt_reg <= '0;
                    hidx_reg    <= hidx_start;
                    age_reg     <= taps_eff - 1'b1;
                    state_reg   <= ST_MAC;
                end
                ST_MAC:
                begin
                    tap_cnt_reg <= tap_cnt_reg + 1'b1;
                    hidx_reg    <= hidx_inc;
                    age_reg     <= age_reg - 1'b1;
                    if (age_reg == '0)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_vld_reg && !mac_busy)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    made_reg  <= 1'b1;
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    state_reg <= ST_STEPW;
                end
                ST_STEPW:
                begin
                    if (div_done)
                    begin
                        phase_reg <= wrap ? '0 : phase_inc[PHASE_W-1:0];
                        qcur_reg  <= wrap ? '0 : div_quo[REG_W-1:0];
                        delta_reg <= delta;
                        if (made_reg)
                        begin
                            state_reg <= ST_PUSH;
                        end
                        else if (delta != '0)
                        begin
                            stno_reg  <= delta - 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            // beyond the second result: advance phase only
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        made_reg <= 1'b0;
                        n_reg    <= n_reg + 1'b1;
                        if (delta_reg != '0)
                        begin
                            stno_reg  <= delta_reg - 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else if (n_reg == 2'd0)
                        begin
                            state_reg <= ST_ROW;
                        end
                        else
                        begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds one result so the next item can be taken
    // ------------------------------------------------------------------
    logic push;

    assign push = (state_reg == ST_PUSH) & out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= mac_result;
            // last when no further output is due on this sample,
            // or when this is the second one
            out_last_reg <= (delta_reg != '0) | (n_reg == 2'd1);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/prr_checker.sv =====
// ----------------------------------------------------------------------------
// prr_checker
// Port-level checks for the polyphase rational resampler.
// ----------------------------------------------------------------------------
module prr_checker
    import prr_pkg::*;
#(
    parameter int M_TDATA_W = 24
)(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 pready
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // a coefficient write completes in its transfer cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_COEF) |=> s_tready)
        else $error("busy after coefficient write");

    // results are only produced while an item is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind polyphase_rational_resampler prr_checker #(
    .M_TDATA_W (M_TDATA_W)
) u_prr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
